FILE: rtl/mbca_pkg.sv
// ============================================================================
// mbca_pkg
// Shared types, constants and helpers of the MIME byte class analyzer.
// ============================================================================
`default_nettype none

package mbca_pkg;

    // Default width of the byte and line counters.
    localparam int COUNT_BITS_DEF = 32;

    // Reset value of the line length limit register.
    localparam logic [15:0] LINE_LIMIT_RESET = 16'd988;

    // Width of one result word, padded to whole bytes.
    localparam int RESULT_BITS = 296;

    // Characters the scanner looks for.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // Length of the "From " pattern.
    localparam logic [2:0] FROM_LEN = 3'd5;

    // Result class of a buffer.
    typedef enum logic [2:0] {
        CLS_BINARY     = 3'd0,
        CLS_EIGHT_DATA = 3'd1,
        CLS_EIGHT_TEXT = 3'd2,
        CLS_SEVEN_DATA = 3'd3,
        CLS_SEVEN_TEXT = 3'd4
    } data_class_t;

    // Decoded properties of one byte.
    typedef struct packed {
        logic is_nul;
        logic is_cr;
        logic is_lf;
        logic is_print;
        logic is_ctl;
        logic is_high;
        logic is_blank;
        logic is_from_f;
    } byte_class_t;

    // Character of "From " expected at a given match position.
    function automatic logic [7:0] from_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h46; // 'F'
            3'd1:    c = 8'h72; // 'r'
            3'd2:    c = 8'h6F; // 'o'
            3'd3:    c = 8'h6D; // 'm'
            3'd4:    c = 8'h20; // ' '
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mbca_byte_decode.sv
// ============================================================================
// mbca_byte_decode
// Sorts one byte into the classes that the analyzer counts.
// ============================================================================
`default_nettype none

module mbca_byte_decode
    import mbca_pkg::*;
(
    input  wire logic [7:0]  data_byte,
    output byte_class_t      byte_class
);

    // Exactly one of the counted classes is set for every byte.
    always_comb
    begin
        byte_class           = '0;
        byte_class.is_blank  = (data_byte == CHAR_TAB) || (data_byte == CHAR_SPACE);
        byte_class.is_from_f = (data_byte == from_char(3'd0));
        if (data_byte == CHAR_NUL)
        begin
            byte_class.is_nul = 1'b1;
        end
        else if (data_byte == CHAR_CR)
        begin
            byte_class.is_cr = 1'b1;
        end
        else if (data_byte == CHAR_LF)
        begin
            byte_class.is_lf = 1'b1;
        end
        else if ((data_byte == CHAR_TAB) || (data_byte inside {[8'h20:8'h7E]}))
        begin
            byte_class.is_print = 1'b1;
        end
        else if ((data_byte == CHAR_DEL) || (data_byte inside {[8'h00:8'h1F]}))
        begin
            byte_class.is_ctl = 1'b1;
        end
        else
        begin
            byte_class.is_high = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mime_byte_class_analyzer.sv
// ============================================================================
// mime_byte_class_analyzer
// Scans a message buffer one byte per word and classifies it on the last byte.
// ============================================================================
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast last_byte
//  m_*       out  m_tvalid/m_tready  m_tdata: class, flags, nine 32-bit counts
//  cfg_*     in   cfg_we             cfg_wdata[15:0] line_limit
//
//  One byte is taken every cycle unless a last byte waits for the result
//  register. A byte goes through the input register and then updates the
//  counters; a last byte writes the result register instead, in that same cycle.
//  A waiting result stalls only a following last byte, not ordinary bytes.
//  Reset clears the counters and flags, sets the shortest line to all ones and sets the line limit to 988.
//
`default_nettype none

module mime_byte_class_analyzer
    import mbca_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream: tdata[7:0] data_byte; tlast last_byte.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tlast,
    // Result stream, lowest bit up: data_class[2:0], trailing_space,
    // leading_from, longest_line, shortest_line, total_bytes, nul_total,
    // control_total, printable_total, high_bit_total, linefeed_total,
    // crlf_total (32 bits each), three zero pad bits.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [RESULT_BITS-1:0]      m_tdata,
    // Line limit register write.
    input  wire logic                   cfg_we,
    input  wire logic [15:0]            cfg_wdata
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int CTL_W = COUNT_BITS + 3;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // Saturating increment.
    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

    // Clamp a counter to the 32-bit result field.
    function automatic logic [31:0] out32(input cnt_t v);
        cnt_t hi;
        hi = v >> 32;
        return (hi != '0) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    // Input register and control.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    // Configuration and scan state.
    logic [15:0] line_limit_reg;
    cnt_t        nul_cnt_reg, cr_cnt_reg, lf_cnt_reg, crlf_cnt_reg, ctl_cnt_reg;
    cnt_t        print_cnt_reg, high_cnt_reg, byte_cnt_reg;
    cnt_t        line_len_reg, line_max_reg, line_min_reg;
    logic [7:0]  prev_reg, prev_prev_reg;
    logic [2:0]  from_match_reg;
    logic        ws_flag_reg, from_flag_reg;

    // Next values.
    cnt_t        nul_cnt_next, cr_cnt_next, lf_cnt_next, crlf_cnt_next, ctl_cnt_next;
    cnt_t        print_cnt_next, high_cnt_next, byte_cnt_next;
    cnt_t        line_len_next, line_max_next, line_min_next;
    logic [2:0]  from_match_next;
    logic        ws_flag_next, from_flag_next;

    logic [RESULT_BITS-1:0] result_reg, result_next;

    byte_class_t bc;
    logic        cr_before;
    cnt_t        len_inc, len_closed, len_final;
    cnt_t        max_mid, min_mid, max_fin, min_fin;
    logic        ws_line_end, ws_fin;
    logic [CTL_W-1:0] ctl_times5;
    logic        is_data;
    data_class_t cls;

    mbca_byte_decode u_decode
    (
        .data_byte  (in_byte_reg),
        .byte_class (bc)
    );

    // Handshake: a byte moves on unless it is a last byte and the result
    // register is still full.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Per-byte update of the counters, lines and flags.
    always_comb
    begin
        cr_before      = (prev_reg == CHAR_CR);
        byte_cnt_next  = sat_inc(byte_cnt_reg);
        nul_cnt_next   = bc.is_nul   ? sat_inc(nul_cnt_reg)   : nul_cnt_reg;
        cr_cnt_next    = bc.is_cr    ? sat_inc(cr_cnt_reg)    : cr_cnt_reg;
        lf_cnt_next    = bc.is_lf    ? sat_inc(lf_cnt_reg)    : lf_cnt_reg;
        ctl_cnt_next   = bc.is_ctl   ? sat_inc(ctl_cnt_reg)   : ctl_cnt_reg;
        print_cnt_next = bc.is_print ? sat_inc(print_cnt_reg) : print_cnt_reg;
        high_cnt_next  = bc.is_high  ? sat_inc(high_cnt_reg)  : high_cnt_reg;
        crlf_cnt_next  = (bc.is_lf && cr_before) ? sat_inc(crlf_cnt_reg) : crlf_cnt_reg;

        // A line feed closes the line; a CR right before it is not counted.
        len_inc    = sat_inc(line_len_reg);
        len_closed = cr_before ? (len_inc - cnt_t'(2)) : (len_inc - cnt_t'(1));
        max_mid    = (bc.is_lf && (len_closed > line_max_reg)) ? len_closed : line_max_reg;
        min_mid    = (bc.is_lf && (len_closed < line_min_reg)) ? len_closed : line_min_reg;
        line_len_next = bc.is_lf ? '0 : len_inc;
        line_max_next = max_mid;
        line_min_next = min_mid;

        // Blank right before the line end, with or without a CR between.
        ws_line_end  = bc.is_lf && ((prev_prev_reg == CHAR_TAB || prev_prev_reg == CHAR_SPACE)
                                    && cr_before
                                    || prev_reg == CHAR_TAB || prev_reg == CHAR_SPACE);
        ws_flag_next = ws_flag_reg || ws_line_end;

        // Match of "From " at the start of a line.
        from_flag_next = from_flag_reg;
        if (bc.is_from_f && (prev_reg == CHAR_LF))
        begin
            from_match_next = 3'd1;
        end
        else if ((from_match_reg != 3'd0) && (from_match_reg < FROM_LEN)
                 && (in_byte_reg == from_char(from_match_reg)))
        begin
            if (from_match_reg + 3'd1 == FROM_LEN)
            begin
                from_match_next = 3'd0;
                from_flag_next  = 1'b1;
            end
            else
            begin
                from_match_next = from_match_reg + 3'd1;
            end
        end
        else
        begin
            from_match_next = 3'd0;
        end

        // The final line is closed at the end of the buffer as well.
        len_final = line_len_next;
        max_fin   = (len_final > max_mid) ? len_final : max_mid;
        min_fin   = (len_final < min_mid) ? len_final : min_mid;
        ws_fin    = ws_flag_next || bc.is_blank;

        // Control share above one fifth, tested as ctl * 5 > total.
        ctl_times5 = (CTL_W'(ctl_cnt_next) << 2) + CTL_W'(ctl_cnt_next);
        is_data = (CMP_W'(max_fin) > CMP_W'(line_limit_reg))
               || ((lf_cnt_next != crlf_cnt_next) && (crlf_cnt_next != '0))
               || (cr_cnt_next != crlf_cnt_next)
               || (ctl_times5 > CTL_W'(byte_cnt_next));

        if (nul_cnt_next != '0)
        begin
            cls = CLS_BINARY;
        end
        else if (high_cnt_next != '0)
        begin
            cls = is_data ? CLS_EIGHT_DATA : CLS_EIGHT_TEXT;
        end
        else
        begin
            cls = is_data ? CLS_SEVEN_DATA : CLS_SEVEN_TEXT;
        end

        result_next = {3'b000,
                       out32(crlf_cnt_next), out32(lf_cnt_next), out32(high_cnt_next),
                       out32(print_cnt_next), out32(ctl_cnt_next), out32(nul_cnt_next),
                       out32(byte_cnt_next), out32(min_fin), out32(max_fin),
                       from_flag_next, ws_fin, cls};
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Line limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LINE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            line_limit_reg <= cfg_wdata;
        end
    end

    // Scan state: updated per byte, cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nul_cnt_reg    <= '0;
            cr_cnt_reg     <= '0;
            lf_cnt_reg     <= '0;
            crlf_cnt_reg   <= '0;
            ctl_cnt_reg    <= '0;
            print_cnt_reg  <= '0;
            high_cnt_reg   <= '0;
            byte_cnt_reg   <= '0;
            line_len_reg   <= '0;
            line_max_reg   <= '0;
            line_min_reg   <= '1;
            prev_reg       <= CHAR_LF;
            prev_prev_reg  <= CHAR_NUL;
            from_match_reg <= 3'd0;
            ws_flag_reg    <= 1'b0;
            from_flag_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                nul_cnt_reg    <= '0;
                cr_cnt_reg     <= '0;
                lf_cnt_reg     <= '0;
                crlf_cnt_reg   <= '0;
                ctl_cnt_reg    <= '0;
                print_cnt_reg  <= '0;
                high_cnt_reg   <= '0;
                byte_cnt_reg   <= '0;
                line_len_reg   <= '0;
                line_max_reg   <= '0;
                line_min_reg   <= '1;
                prev_reg       <= CHAR_LF;
                prev_prev_reg  <= CHAR_NUL;
                from_match_reg <= 3'd0;
                ws_flag_reg    <= 1'b0;
                from_flag_reg  <= 1'b0;
            end
            else
            begin
                nul_cnt_reg    <= nul_cnt_next;
                cr_cnt_reg     <= cr_cnt_next;
                lf_cnt_reg     <= lf_cnt_next;
                crlf_cnt_reg   <= crlf_cnt_next;
                ctl_cnt_reg    <= ctl_cnt_next;
                print_cnt_reg  <= print_cnt_next;
                high_cnt_reg   <= high_cnt_next;
                byte_cnt_reg   <= byte_cnt_next;
                line_len_reg   <= line_len_next;
                line_max_reg   <= line_max_next;
                line_min_reg   <= line_min_next;
                prev_reg       <= in_byte_reg;
                prev_prev_reg  <= prev_reg;
                from_match_reg <= from_match_next;
                ws_flag_reg    <= ws_flag_next;
                from_flag_reg  <= from_flag_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            result_reg <= result_next;
        end
    end

    // A finished buffer leaves the scan state at its reset values.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> byte_cnt_reg == '0 && prev_reg == CHAR_LF
                                   && line_min_reg == '1)
        else $error("scan state not cleared after last byte");

    // Every CR LF pair has been counted as a CR and as an LF.
    assert property (@(posedge clk) disable iff (!rst_n)
        crlf_cnt_reg <= lf_cnt_reg && crlf_cnt_reg <= cr_cnt_reg)
        else $error("CR LF count exceeds CR or LF count");

    // The pattern match never runs past its last character.
    assert property (@(posedge clk) disable iff (!rst_n)
        from_match_reg < FROM_LEN)
        else $error("From match position out of range");

    // A byte held in the input register keeps its value while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg))
        else $error("stalled input byte changed");

    // Any NUL byte makes the buffer binary.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[132:101] != 32'd0) |-> m_tdata[2:0] == CLS_BINARY)
        else $error("buffer with NUL not classed binary");

endmodule

`default_nettype wire
